// File: hw/rtl/teq_pkg.sv
// teq_pkg: shared types and constants of the timed event queue
// holds the word structs, op and status codes and the cell control bundle
// no dependencies
package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam logic [15:0] MAX_STEP_RESET = 16'd1024;

  typedef enum logic [2:0] {
    OP_POST      = 3'd0,
    OP_PURGE_ANY = 3'd1,
    OP_PURGE_DST = 3'd2,
    OP_SERVICE   = 3'd3,
    OP_ADVANCE   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_POSTED    = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_WAIT      = 3'd3,
    ST_PURGED    = 3'd4,
    ST_ADVANCED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_PURGE
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_PURGE
  } fsm_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] event_time;
    logic [7:0]  source_gen;
    logic [7:0]  dest_gen;
    logic [3:0]  dest_port;
    logic [15:0] payload_handle;
    logic [7:0]  target_gen;
    logic [15:0] advance_by;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] out_time;
    logic [7:0]  out_source;
    logic [7:0]  out_dest;
    logic [3:0]  out_port;
    logic [15:0] out_payload;
    logic [15:0] wait_samples;
    logic [4:0]  removed_count;
    logic [4:0]  occupancy;
    logic [31:0] now_time;
  } out_word_t;

  // one stored event
  typedef struct packed {
    logic [31:0] due;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [3:0]  port;
    logic [15:0] payload;
  } entry_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    cell_op_t   op;
    logic       either;
    logic [7:0] target;
    entry_t     fresh;
  } cell_ctl_t;

  // flags a cell hands to its right neighbor
  typedef struct packed {
    logic greater;
    logic hole;
  } link_t;

endpackage

// File: hw/rtl/timed_event_queue.sv
// timed_event_queue: post, service and advance load their result word on acceptance; it is
// valid in the output register in the cycle after acceptance
// purge squeezes one matching entry out of the chain per cycle, then loads its result word
// one word is in work at a time; a new word is taken when no purge runs and the output register is free or drains
// reset (synchronous): count, current time and output valid clear, max_step loads 1024;
// slot contents are not cleared
module timed_event_queue #(
  parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  teq_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output teq_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  teq_pkg::fsm_t      state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      removed, removed_next;
  logic [31:0]        now, now_next;
  logic [15:0]        max_step;
  logic               either, either_next;
  logic [7:0]         target, target_next;
  logic               out_load;
  teq_pkg::out_word_t out_next;
  teq_pkg::cell_ctl_t ctl;
  teq_pkg::entry_t    q [QUEUE_DEPTH];
  teq_pkg::link_t     lk [QUEUE_DEPTH];
  teq_pkg::entry_t    head;
  logic               accept;
  logic               due;
  logic [31:0]        gap;
  logic               any_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == teq_pkg::FSM_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign head      = q[0];
  assign due       = (count != '0) && (head.due <= now);
  assign gap       = head.due - now;
  assign any_hit   = lk[QUEUE_DEPTH-1].hole;

  // row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    teq_pkg::entry_t left_e;
    teq_pkg::entry_t right_e;
    teq_pkg::link_t  left_l;
    if (i == 0) begin : g_first
      assign left_e = q[0];
      assign left_l = '0;
    end else begin : g_mid
      assign left_e = q[i-1];
      assign left_l = lk[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = q[i];
    end else begin : g_inner
      assign right_e = q[i+1];
    end
    teq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (count > CW'(i)),
      .left      (left_e),
      .right     (right_e),
      .left_link (left_l),
      .q         (q[i]),
      .link      (lk[i])
    );
  end

  // sequencer: next state, cell command and result word
  always_comb begin
    state_next   = state;
    count_next   = count;
    removed_next = removed;
    now_next     = now;
    either_next  = either;
    target_next  = target;
    out_load     = 1'b0;
    out_next     = '0;
    ctl.op       = teq_pkg::CELL_HOLD;
    ctl.either   = either;
    ctl.target   = target;
    ctl.fresh.due     = in_data.event_time;
    ctl.fresh.src     = in_data.source_gen;
    ctl.fresh.dst     = in_data.dest_gen;
    ctl.fresh.port    = in_data.dest_port;
    ctl.fresh.payload = in_data.payload_handle;
    case (state)
      teq_pkg::FSM_IDLE: begin
        if (accept) begin
          case (teq_pkg::op_t'(in_data.op))
            teq_pkg::OP_POST: begin
              out_load = 1'b1;
              if (count == CW'(QUEUE_DEPTH)) begin
                out_next.status = teq_pkg::ST_DROPPED;
              end else begin
                ctl.op = teq_pkg::CELL_INSERT;
                count_next = count + 1'b1;
                out_next.status = teq_pkg::ST_POSTED;
              end
            end
            teq_pkg::OP_PURGE_ANY, teq_pkg::OP_PURGE_DST: begin
              either_next  = (teq_pkg::op_t'(in_data.op) == teq_pkg::OP_PURGE_ANY);
              target_next  = in_data.target_gen;
              removed_next = '0;
              state_next   = teq_pkg::FSM_PURGE;
            end
            teq_pkg::OP_SERVICE: begin
              out_load = 1'b1;
              if (due) begin
                ctl.op = teq_pkg::CELL_POP;
                count_next = count - 1'b1;
                out_next.status      = teq_pkg::ST_DELIVERED;
                out_next.out_time    = head.due;
                out_next.out_source  = head.src;
                out_next.out_dest    = head.dst;
                out_next.out_port    = head.port;
                out_next.out_payload = head.payload;
              end else begin
                out_next.status = teq_pkg::ST_WAIT;
                if ((count != '0) && (gap < {16'd0, max_step})) begin
                  out_next.wait_samples = gap[15:0];
                end else begin
                  out_next.wait_samples = max_step;
                end
              end
            end
            teq_pkg::OP_ADVANCE: begin
              out_load = 1'b1;
              now_next = now + {16'd0, in_data.advance_by};
              out_next.status = teq_pkg::ST_ADVANCED;
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      teq_pkg::FSM_PURGE: begin
        // squeeze out the first matching entry each cycle
        if (any_hit) begin
          ctl.op       = teq_pkg::CELL_PURGE;
          count_next   = count - 1'b1;
          removed_next = removed + 1'b1;
        end else begin
          out_load = 1'b1;
          out_next.status        = teq_pkg::ST_PURGED;
          out_next.removed_count = 5'(removed);
          state_next = teq_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = teq_pkg::FSM_IDLE;
      end
    endcase
    out_next.occupancy = 5'(count_next);
    out_next.now_time  = now_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= teq_pkg::FSM_IDLE;
      count     <= '0;
      now       <= '0;
      max_step  <= teq_pkg::MAX_STEP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      now   <= now_next;
      if (cfg_valid && cfg_ready) begin
        max_step <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    removed <= removed_next;
    either  <= either_next;
    target  <= target_next;
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("event count beyond queue depth");

  a_purge_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == teq_pkg::FSM_PURGE) |-> !out_valid)
    else $error("result word pending during purge");

  a_post_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.op == teq_pkg::OP_POST) && (count < CW'(QUEUE_DEPTH)))
    |=> (count == $past(count) + 1'b1))
    else $error("post did not add an entry");

  a_delivered_due: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.op == teq_pkg::OP_SERVICE) && due)
    |=> (out_data.out_time <= out_data.now_time))
    else $error("delivered event not yet due");

endmodule

// File: hw/rtl/teq_cell.sv
// teq_cell: one slot of the sorted event chain
// depends on teq_pkg for entry_t, cell_ctl_t and link_t
module teq_cell (
  input  logic               clk,
  input  teq_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  teq_pkg::entry_t    left,
  input  teq_pkg::entry_t    right,
  input  teq_pkg::link_t     left_link,
  output teq_pkg::entry_t    q,
  output teq_pkg::link_t     link
);

  logic greater;
  logic hit;
  teq_pkg::entry_t q_next;

  // compare against the new event and the purge target
  assign greater = occ && (q.due > ctl.fresh.due);
  assign hit = occ && ((q.dst == ctl.target) || (ctl.either && (q.src == ctl.target)));
  assign link.greater = greater;
  assign link.hole = left_link.hole | hit;

  // slot update
  always_comb begin
    q_next = q;
    case (ctl.op)
      teq_pkg::CELL_INSERT: begin
        if (left_link.greater) begin
          q_next = left;
        end else if (greater || !occ) begin
          q_next = ctl.fresh;
        end
      end
      teq_pkg::CELL_POP: begin
        q_next = right;
      end
      teq_pkg::CELL_PURGE: begin
        if (left_link.hole || hit) begin
          q_next = right;
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// File: tb/timed_event_queue_test.sv
// timed_event_queue_test: self-checking bench for the timed event queue
// drives post, purge, service, advance and undefined-op words, predicts every result word in-bench
// depends on teq_pkg and timed_event_queue
module timed_event_queue_test;

  localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;
  localparam int WORDS_PER_PHASE = 290;
  localparam int DRAIN_CYCLES    = 30;
  localparam int HOLD_AT         = 400;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  teq_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  teq_pkg::out_word_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;

  // queue state as the bench sees it
  teq_pkg::entry_t    model_events[$];
  logic [31:0]        model_now = '0;
  logic [15:0]        model_max_step = teq_pkg::MAX_STEP_RESET;
  teq_pkg::out_word_t predicted_words[$];

  // words waiting to be offered, and the time the generator expects after them
  teq_pkg::in_word_t  stim_words[$];
  logic [31:0]        plan_now = '0;
  logic [31:0]        last_due = '0;

  int  send_gap = 0;
  bit  send_burst = 1'b0;
  int  recv_wait = 0;
  bit  recv_burst = 1'b0;
  int  results_seen = 0;
  int  quiet_cycles = 0;
  int  error_count = 0;

  timed_event_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // work out the result word of one accepted word and update the queue state
  function automatic void predict_response(teq_pkg::in_word_t w);
    teq_pkg::out_word_t r;
    teq_pkg::entry_t    e;
    teq_pkg::entry_t    kept[$];
    int                 pos;
    int                 removed;
    logic [31:0]        gap;
    r = '0;
    case (w.op)
      teq_pkg::OP_POST: begin
        if (model_events.size() >= teq_pkg::QUEUE_DEPTH) begin
          r.status = teq_pkg::ST_DROPPED;
        end else begin
          e.due = w.event_time;
          e.src = w.source_gen;
          e.dst = w.dest_gen;
          e.port = w.dest_port;
          e.payload = w.payload_handle;
          // behind every entry due at or before this one
          pos = 0;
          while (pos < model_events.size() && model_events[pos].due <= w.event_time) pos++;
          model_events.insert(pos, e);
          r.status = teq_pkg::ST_POSTED;
        end
      end
      teq_pkg::OP_PURGE_ANY, teq_pkg::OP_PURGE_DST: begin
        removed = 0;
        foreach (model_events[i]) begin
          if (model_events[i].dst == w.target_gen ||
              (w.op == teq_pkg::OP_PURGE_ANY && model_events[i].src == w.target_gen)) begin
            removed++;
          end else begin
            kept.push_back(model_events[i]);
          end
        end
        model_events = kept;
        r.status = teq_pkg::ST_PURGED;
        r.removed_count = 5'(removed);
      end
      teq_pkg::OP_SERVICE: begin
        if (model_events.size() > 0 && model_events[0].due <= model_now) begin
          e = model_events.pop_front();
          r.status = teq_pkg::ST_DELIVERED;
          r.out_time = e.due;
          r.out_source = e.src;
          r.out_dest = e.dst;
          r.out_port = e.port;
          r.out_payload = e.payload;
        end else begin
          // nothing due: wait to the head, clamped
          r.status = teq_pkg::ST_WAIT;
          r.wait_samples = model_max_step;
          if (model_events.size() > 0) begin
            gap = model_events[0].due - model_now;
            if (gap < {16'd0, model_max_step}) r.wait_samples = gap[15:0];
          end
        end
      end
      teq_pkg::OP_ADVANCE: begin
        model_now = model_now + {16'd0, w.advance_by};
        r.status = teq_pkg::ST_ADVANCED;
      end
      default: return;
    endcase
    r.occupancy = 5'(model_events.size());
    r.now_time = model_now;
    predicted_words.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void compare_word(teq_pkg::out_word_t want, teq_pkg::out_word_t got);
    check_field("status", want.status, got.status);
    check_field("out_time", want.out_time, got.out_time);
    check_field("out_source", want.out_source, got.out_source);
    check_field("out_dest", want.out_dest, got.out_dest);
    check_field("out_port", want.out_port, got.out_port);
    check_field("out_payload", want.out_payload, got.out_payload);
    check_field("wait_samples", want.wait_samples, got.wait_samples);
    check_field("removed_count", want.removed_count, got.removed_count);
    check_field("occupancy", want.occupancy, got.occupancy);
    check_field("now_time", want.now_time, got.now_time);
  endfunction

  // input side: offer queued words with random gaps, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) predict_response(in_data);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (stim_words.size() > 0) begin
          in_data <= stim_words.pop_front();
          in_valid <= 1'b1;
          send_gap <= send_burst ? 0 : $urandom_range(0, 5);
          if ($urandom_range(0, 63) == 0) send_burst <= !send_burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: check result words, stall at random, one long hold-off
  always @(posedge clk) begin : result_monitor
    int stall;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (out_valid && out_ready) begin
      if (predicted_words.size() == 0) begin
        $error("result word with no prediction waiting");
        error_count++;
      end else begin
        compare_word(predicted_words.pop_front(), out_data);
      end
      results_seen++;
      if (results_seen == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else begin
        stall = recv_burst ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 63) == 0) recv_burst <= !recv_burst;
      end
      recv_wait <= stall;
      out_ready <= (stall == 0);
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= (recv_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timed_event_queue_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_word(teq_pkg::in_word_t w);
    stim_words.push_back(w);
    if (w.op == teq_pkg::OP_ADVANCE) plan_now = plan_now + {16'd0, w.advance_by};
  endfunction

  // mostly a small pool so purges hit, sometimes any generator
  function automatic logic [7:0] pick_gen();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
  endfunction

  // random content shaped around the time the queue will have reached
  function automatic teq_pkg::in_word_t make_word(logic [2:0] op);
    teq_pkg::in_word_t w;
    w.op = op;
    case ($urandom_range(0, 9))
      0: w.event_time = $urandom;
      1: w.event_time = plan_now - $urandom_range(0, 3000);
      2: w.event_time = last_due;
      default: w.event_time = plan_now + $urandom_range(0, 2500);
    endcase
    if (op == teq_pkg::OP_POST) last_due = w.event_time;
    w.source_gen = pick_gen();
    w.dest_gen = pick_gen();
    w.dest_port = 4'($urandom);
    w.payload_handle = 16'($urandom);
    w.target_gen = pick_gen();
    w.advance_by = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
    return w;
  endfunction

  function automatic void directed_word(logic [2:0] op, logic [31:0] due, logic [7:0] src,
                                        logic [7:0] dst, logic [3:0] port, logic [15:0] pay,
                                        logic [7:0] target, logic [15:0] step);
    queue_word('{op, due, src, dst, port, pay, target, step});
  endfunction

  function automatic void random_phase(int count);
    teq_pkg::in_word_t w;
    logic [7:0]        g;
    int                made;
    int                pick;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 39) == 0) begin
        // burst of posts to one destination runs the store full
        g = pick_gen();
        repeat (teq_pkg::QUEUE_DEPTH + 2) begin
          w = make_word(teq_pkg::OP_POST);
          w.dest_gen = g;
          queue_word(w);
        end
        made += teq_pkg::QUEUE_DEPTH + 2;
        if ($urandom_range(0, 1) == 1) begin
          w = make_word(teq_pkg::OP_PURGE_DST);
          w.target_gen = g;
          queue_word(w);
          made++;
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          queue_word(make_word(3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST))));
          made++;
        end else begin
          if (pick < 41) w = make_word(teq_pkg::OP_POST);
          else if (pick < 71) w = make_word(teq_pkg::OP_SERVICE);
          else if (pick < 87) w = make_word(teq_pkg::OP_ADVANCE);
          else if (pick < 94) w = make_word(teq_pkg::OP_PURGE_ANY);
          else w = make_word(teq_pkg::OP_PURGE_DST);
          queue_word(w);
          made++;
        end
      end
    end
  endfunction

  // block until idle: nothing queued, offered or predicted, then drain
  task automatic wait_idle();
    do @(posedge clk);
    while (stim_words.size() != 0 || in_valid || predicted_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_step(logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_max_step = value;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty service, extremes, equal times, purge kinds, ignored ops
    directed_word(teq_pkg::OP_SERVICE, '0, '0, '0, '0, '0, '0, '0);
    directed_word(teq_pkg::OP_ADVANCE, '0, '0, '0, '0, '0, '0, '0);
    directed_word(teq_pkg::OP_POST, '1, '1, '1, '1, '1, '1, '1);
    directed_word(teq_pkg::OP_POST, '0, '0, '0, '0, '0, '0, '0);
    directed_word(teq_pkg::OP_POST, 32'd5, 8'd1, 8'd2, 4'd3, 16'h1111, '0, '0);
    directed_word(teq_pkg::OP_POST, 32'd5, 8'd3, 8'd4, 4'd5, 16'h2222, '0, '0);
    directed_word(teq_pkg::OP_SERVICE, '0, '0, '0, '0, '0, '0, '0);
    directed_word(teq_pkg::OP_SERVICE, '0, '0, '0, '0, '0, '0, '0);
    directed_word(teq_pkg::OP_ADVANCE, '0, '0, '0, '0, '0, '0, '1);
    directed_word(teq_pkg::OP_SERVICE, '1, '1, '1, '1, '1, '1, '0);
    directed_word(teq_pkg::OP_SERVICE, '0, '0, '0, '0, '0, '0, '0);
    directed_word(teq_pkg::OP_SERVICE, '0, '0, '0, '0, '0, '0, '0);
    directed_word(teq_pkg::OP_POST, 32'd100, 8'd9, 8'd8, 4'd1, 16'h0123, '0, '0);
    directed_word(teq_pkg::OP_POST, 32'd100, 8'd8, 8'd9, 4'd2, 16'h4567, '0, '0);
    directed_word(teq_pkg::OP_PURGE_DST, '0, '0, '0, '0, '0, 8'd8, '0);
    directed_word(teq_pkg::OP_PURGE_ANY, '0, '0, '0, '0, '0, 8'd8, '0);
    directed_word(teq_pkg::OP_PURGE_ANY, '0, '0, '0, '0, '0, '1, '0);
    directed_word(teq_pkg::OP_PURGE_DST, '0, '0, '0, '0, '0, '0, '0);
    directed_word(OP_UNDEF_FIRST, '1, '1, '1, '1, '1, '1, '1);
    directed_word(OP_UNDEF_LAST, '1, '1, '1, '1, '1, '1, '1);
    directed_word(teq_pkg::OP_SERVICE, '0, '0, '0, '0, '0, '0, '0);

    // reset value of max_step first, then zero, full scale, one and a random one
    random_phase(WORDS_PER_PHASE);
    wait_idle();
    write_max_step(16'd0);
    random_phase(WORDS_PER_PHASE);
    wait_idle();
    write_max_step(16'hFFFF);
    random_phase(WORDS_PER_PHASE);
    wait_idle();
    write_max_step(16'd1);
    random_phase(WORDS_PER_PHASE);
    wait_idle();
    write_max_step(16'($urandom_range(2, 65534)));
    random_phase(WORDS_PER_PHASE);
    wait_idle();

    if (error_count == 0) begin
      $display("timed_event_queue_test: clean");
    end else begin
      $display("timed_event_queue_test: errors");
    end
    $finish;
  end

endmodule

// File: timed_event_queue.f
hw/rtl/teq_pkg.sv
hw/rtl/teq_cell.sv
hw/rtl/timed_event_queue.sv
tb/timed_event_queue_test.sv
